[rtl/rblao_pkg.sv]
// Package: opcodes, command codes, register indexes and reset values of the relay bank.
`timescale 1ns / 1ps

package rblao_pkg;

    // opcode field
    localparam logic [1:0] OP_POLL    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_TOUCH   = 2'd2;

    // remote command codes
    localparam logic [3:0] CMD_RESTART  = 4'd1;
    localparam logic [3:0] CMD_R1_CLR   = 4'd2;
    localparam logic [3:0] CMD_R1_SET   = 4'd3;
    localparam logic [3:0] CMD_R1_TGL   = 4'd4;
    localparam logic [3:0] CMD_R2_CLR   = 4'd5;
    localparam logic [3:0] CMD_R2_ARM   = 4'd6;
    localparam logic [3:0] CMD_R2_TGL   = 4'd7;
    localparam logic [3:0] CMD_R3_CLR   = 4'd8;
    localparam logic [3:0] CMD_R3_SET   = 4'd9;
    localparam logic [3:0] CMD_R3_TGL   = 4'd10;
    localparam logic [3:0] CMD_R4_CLR   = 4'd11;
    localparam logic [3:0] CMD_R4_SET   = 4'd12;
    localparam logic [3:0] CMD_R4_TGL   = 4'd13;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCKOUT  = 2'd0;
    localparam logic [1:0] CFG_AUTO_OFF = 2'd1;
    localparam logic [1:0] CFG_TOUCH_EN = 2'd2;

    localparam int unsigned CFG_DATA_W = 32;

    // reset values
    localparam logic [15:0] LOCKOUT_RST  = 16'd500;
    localparam logic [31:0] AUTO_OFF_RST = 32'd10000;
    localparam logic [3:0]  RELAY_RST    = 4'hF;

endpackage

[rtl/rblao_in_if.sv]
// Interface: input word channel of the relay bank (event with timestamp).
`timescale 1ns / 1ps

interface rblao_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  command_code;
    logic [1:0]  channel;
    logic [31:0] now_ms;

    modport source (output valid, output opcode, output command_code, output channel,
                    output now_ms, input ready);
    modport sink   (input valid, input opcode, input command_code, input channel,
                    input now_ms, output ready);
endinterface

[rtl/rblao_out_if.sv]
// Interface: result word channel of the relay bank.
`timescale 1ns / 1ps

interface rblao_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] relay_state;
    logic       report;
    logic       restart;

    modport source (output valid, output relay_state, output report, output restart,
                    input ready);
    modport sink   (input valid, input relay_state, input report, input restart,
                    output ready);
endinterface

[rtl/relay_bank_lockout_autooff.sv]
// Top level: relay bank with action lockout, change-edge halving and relay 2 auto-off.
`timescale 1ns / 1ps

// Four relay bits driven by timestamped events (poll, remote command, touch).
// Each accepted word lands in an input register, is decoded against the relay,
// lockout and timer state combinationally, and leaves one result word in an output
// register. One word per cycle is sustained while the result side is ready; a stalled
// result word holds the word in the input register. A word passes the input register
// and then the output register, and the state updates in the same cycle as the output
// register loads, so the next word always sees the state the previous one left.
// Configuration writes take effect on the next edge and are meant for idle time.
module relay_bank_lockout_autooff (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [rblao_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    rblao_in_if.sink                         i_item,
    rblao_out_if.source                      o_result
);

    // configuration
    logic [15:0] r_lockout_ms;
    logic [31:0] r_auto_off_ms;
    logic        r_touch_en;

    // block state
    logic [3:0]  r_relay, n_relay;
    logic [31:0] r_last_ms, n_last_ms;
    logic        r_armed, n_armed;
    logic [31:0] r_start_ms, n_start_ms;
    logic [1:0]  r_edge_phase, n_edge_phase;

    // input stage
    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [3:0]  r_cmd;
    logic [1:0]  r_channel;
    logic [31:0] r_now_ms;

    // output stage
    logic        r_out_valid;
    logic [3:0]  r_out_relay;
    logic        r_out_report;
    logic        r_out_restart;
    logic        n_report, n_restart;

    logic        advance;
    logic        in_ready;
    logic        locked;
    logic        expired;
    logic [31:0] since_action;
    logic [31:0] since_start;
    logic        phase_bit;

    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready         = in_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.relay_state = r_out_relay;
    assign o_result.report      = r_out_report;
    assign o_result.restart     = r_out_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ms  <= rblao_pkg::LOCKOUT_RST;
            r_auto_off_ms <= rblao_pkg::AUTO_OFF_RST;
            r_touch_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rblao_pkg::CFG_LOCKOUT:  r_lockout_ms  <= i_cfg_wdata[15:0];
                rblao_pkg::CFG_AUTO_OFF: r_auto_off_ms <= i_cfg_wdata[31:0];
                rblao_pkg::CFG_TOUCH_EN: r_touch_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_opcode  <= i_item.opcode;
            r_cmd     <= i_item.command_code;
            r_channel <= i_item.channel;
            r_now_ms  <= i_item.now_ms;
        end
    end

    assign since_action = r_now_ms - r_last_ms;
    assign since_start  = r_now_ms - r_start_ms;
    assign locked       = since_action < {16'd0, r_lockout_ms};
    assign expired      = r_armed && (since_start > r_auto_off_ms);
    assign phase_bit    = r_edge_phase[r_channel[0]];

    always_comb begin
        n_relay      = r_relay;
        n_last_ms    = r_last_ms;
        n_armed      = r_armed;
        n_start_ms   = r_start_ms;
        n_edge_phase = r_edge_phase;
        n_report     = 1'b0;
        n_restart    = 1'b0;

        case (r_opcode)
            rblao_pkg::OP_POLL: begin
                if (expired) begin
                    n_armed    = 1'b0;
                    n_relay[1] = 1'b0;
                    n_report   = 1'b1;
                end
            end
            rblao_pkg::OP_COMMAND: begin
                case (r_cmd)
                    rblao_pkg::CMD_RESTART: begin
                        n_relay      = rblao_pkg::RELAY_RST;
                        n_last_ms    = '0;
                        n_armed      = 1'b0;
                        n_start_ms   = '0;
                        n_edge_phase = '0;
                        n_restart    = 1'b1;
                    end
                    rblao_pkg::CMD_R1_CLR, rblao_pkg::CMD_R1_SET: begin
                        n_relay[0] = (r_cmd == rblao_pkg::CMD_R1_SET);
                        n_last_ms  = r_now_ms;
                    end
                    rblao_pkg::CMD_R2_CLR: begin
                        n_relay[1] = 1'b0;
                        n_last_ms  = r_now_ms;
                    end
                    rblao_pkg::CMD_R2_ARM: begin
                        n_relay[1] = 1'b1;
                        n_last_ms  = r_now_ms;
                        n_start_ms = r_now_ms;
                        n_armed    = 1'b1;
                    end
                    rblao_pkg::CMD_R2_TGL: begin
                        if (!locked) begin
                            n_relay[1] = !r_relay[1];
                            n_last_ms  = r_now_ms;
                        end
                        // arm when relay 2 ends up on, toggled or not
                        if (n_relay[1]) begin
                            n_start_ms = r_now_ms;
                            n_armed    = 1'b1;
                        end
                    end
                    rblao_pkg::CMD_R3_CLR, rblao_pkg::CMD_R3_SET: begin
                        if (!locked) begin
                            n_relay[2] = (r_cmd == rblao_pkg::CMD_R3_SET);
                            n_last_ms  = r_now_ms;
                        end
                    end
                    rblao_pkg::CMD_R4_CLR, rblao_pkg::CMD_R4_SET: begin
                        n_relay[3] = (r_cmd == rblao_pkg::CMD_R4_SET);
                        n_last_ms  = r_now_ms;
                    end
                    rblao_pkg::CMD_R1_TGL, rblao_pkg::CMD_R3_TGL, rblao_pkg::CMD_R4_TGL: begin
                        if (!locked) begin
                            case (r_cmd)
                                rblao_pkg::CMD_R1_TGL: n_relay[0] = !r_relay[0];
                                rblao_pkg::CMD_R3_TGL: n_relay[2] = !r_relay[2];
                                default:               n_relay[3] = !r_relay[3];
                            endcase
                            n_last_ms = r_now_ms;
                        end
                    end
                    default: ;
                endcase
            end
            rblao_pkg::OP_TOUCH: begin
                if (r_touch_en && !locked) begin
                    if (!r_channel[1]) begin
                        n_relay[r_channel] = !r_relay[r_channel];
                        n_last_ms          = r_now_ms;
                        n_report           = 1'b1;
                        // touch on channel 1 turning relay 2 on restarts the start time only
                        if (r_channel[0] && !r_relay[1]) begin
                            n_start_ms = r_now_ms;
                        end
                    end else begin
                        // change edges act on every second one
                        if (!phase_bit) begin
                            n_relay[r_channel] = !r_relay[r_channel];
                            n_last_ms          = r_now_ms;
                            n_report           = 1'b1;
                        end
                        n_edge_phase[r_channel[0]] = !phase_bit;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay      <= rblao_pkg::RELAY_RST;
            r_last_ms    <= '0;
            r_armed      <= 1'b0;
            r_start_ms   <= '0;
            r_edge_phase <= '0;
        end else if (advance) begin
            r_relay      <= n_relay;
            r_last_ms    <= n_last_ms;
            r_armed      <= n_armed;
            r_start_ms   <= n_start_ms;
            r_edge_phase <= n_edge_phase;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_relay   <= n_relay;
            r_out_report  <= n_report;
            r_out_restart <= n_restart;
        end
    end

endmodule

[rtl/rblao_checker.sv]
// Checker: port-level assertions for the relay bank, bound to the top level.
`timescale 1ns / 1ps

module rblao_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_relay_state,
    input logic       i_report,
    input logic       i_restart
);

    // a restart word always shows the reset relay pattern
    a_restart_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_restart |-> i_relay_state == rblao_pkg::RELAY_RST)
        else $error("restart word without reset relay pattern");

    // restart and report never come together
    a_restart_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_restart && i_report))
        else $error("restart and report in one word");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word right after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_relay_state)
            && $stable(i_report) && $stable(i_restart))
        else $error("stalled result word changed");

endmodule

bind relay_bank_lockout_autooff rblao_checker u_rblao_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_relay_state (o_result.relay_state),
    .i_report      (o_result.report),
    .i_restart     (o_result.restart)
);
